// ===== rtl/bad_block_remap_table_defines.svh =====
// Assertion macros used by the bad block remap table datapath.
`ifndef BAD_BLOCK_REMAP_TABLE_DEFINES_SVH
`define BAD_BLOCK_REMAP_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BBRT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bad_block_remap_table assertion failed");
`define BBRT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bad_block_remap_table assertion failed");
`else
`define BBRT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BBRT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/bbrt_pkg.sv =====
// Types and constants of the bad block remap table.
`default_nettype none
package bbrt_pkg;

    localparam int unsigned SPARE_FLOOR = 3;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_DUP  = 3'd1;
    localparam logic [2:0] ST_CYL  = 3'd2;
    localparam logic [2:0] ST_HEAD = 3'd3;
    localparam logic [2:0] ST_SECT = 3'd4;
    localparam logic [2:0] ST_FULL = 3'd5;
    localparam logic [2:0] ST_POS  = 3'd6;

    localparam logic [2:0] CFG_BLOCKS_PER_CYL = 3'd0;
    localparam logic [2:0] CFG_SECTORS        = 3'd1;
    localparam logic [2:0] CFG_HEADS          = 3'd2;
    localparam logic [2:0] CFG_LAST_CYL       = 3'd3;
    localparam logic [2:0] CFG_SPARE_TOP      = 3'd4;

    typedef struct packed {
        logic [31:0] block;
        logic [15:0] spare;
    } entry_t;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_SH_DN,
        RA_SH_UP,
        RA_POS
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT,
        WR_NEW
    } wr_sel_t;

    typedef enum logic [2:0] {
        RES_ERR,
        RES_FULL,
        RES_DUP,
        RES_NEW,
        RES_HIT,
        RES_MISS,
        RES_ENTRY
    } res_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SUM,
        S_SP_TEST,
        S_SP_RD,
        S_SP_CHK,
        S_DUP_RD,
        S_DUP_CHK,
        S_INS_START,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LK_RD,
        S_LK_CHK,
        S_POS_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     sum;
        logic     idx_clr;
        logic     idx_inc;
        logic     cand_dec;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     sh_load_count;
        logic     sh_load_pos;
        logic     sh_dec;
        logic     sh_inc;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_en;
        res_sel_t res_sel;
        logic [2:0] res_status;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic cyl_bad;
        logic head_bad;
        logic sect_bad;
        logic pos_bad;
        logic cand_low;
        logic idx_end;
        logic spare_eq;
        logic blk_eq;
        logic blk_gt;
        logic look_eq;
        logic full;
        logic sh_at_idx;
        logic del_end;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/bbrt_datapath.sv =====
// Datapath of the bad block remap table: registers, entry memory, compares.
`default_nettype none
`include "bad_block_remap_table_defines.svh"
module bbrt_datapath #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bbrt_pkg::dp_cmd_t  cmd,
    output bbrt_pkg::dp_stat_t      stat,
    input  wire logic [79:0]      s_tdata,
    input  wire logic [1:0]       s_tuser,
    input  wire logic             cfg_valid,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [18:0]      cfg_data,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [71:0]           m_tdata
);
    import bbrt_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    entry_t mem [MAX_ENTRIES];
    entry_t rdata_reg;

    logic [18:0] bpc_reg;
    logic [10:0] spt_reg;
    logic [8:0]  heads_reg;
    logic [15:0] last_cyl_reg;
    logic [15:0] spare_top_reg;

    logic [1:0]  req_reg;
    logic [15:0] cyl_reg;
    logic [7:0]  head_reg;
    logic [9:0]  sect_reg;
    logic [7:0]  pos_reg;
    logic [31:0] look_reg;

    logic [31:0] p1_reg;
    logic [18:0] p2_reg;
    logic [31:0] blk_reg;
    logic [31:0] blk_next;
    logic [15:0] cand_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] sh_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] sh_dn;
    logic [CW-1:0] sh_up;
    logic [34:0] prod_a;
    logic [18:0] prod_b;

    logic [2:0]  res_status_reg;
    logic [31:0] res_block_reg;
    logic [15:0] res_spare_reg;
    logic [CW-1:0] res_pos_reg;
    logic        res_hit_reg;

    logic [2:0]  res_status_next;
    logic [31:0] res_block_next;
    logic [15:0] res_spare_next;
    logic [CW-1:0] res_pos_next;
    logic        res_hit_next;

    logic [31:0] pos_ext;
    logic [31:0] cnt_ext;
    logic [31:0] rpos_ext;
    logic [IW-1:0] raddr;
    logic [IW-1:0] waddr;
    entry_t        wdata;

    logic        m_valid_reg;
    logic [71:0] m_data_reg;

    assign pos_ext  = 32'(pos_reg);
    assign cnt_ext  = 32'(count_reg);
    assign rpos_ext = 32'(res_pos_reg);
    assign sh_dn    = sh_reg - 1'b1;
    assign sh_up    = sh_reg + 1'b1;
    assign prod_a   = {19'b0, cyl_reg} * {16'b0, bpc_reg};
    assign prod_b   = {11'b0, head_reg} * {8'b0, spt_reg};
    assign blk_next = p1_reg + {13'b0, p2_reg} + {22'b0, sect_reg};

    always_comb begin
        case (cmd.rd_sel)
            RA_IDX:   raddr = idx_reg[IW-1:0];
            RA_SH_DN: raddr = sh_dn[IW-1:0];
            RA_SH_UP: raddr = sh_up[IW-1:0];
            RA_POS:   raddr = pos_ext[IW-1:0];
            default:  raddr = idx_reg[IW-1:0];
        endcase
        if (cmd.wr_sel == WR_NEW) begin
            waddr = idx_reg[IW-1:0];
            wdata = '{block: blk_reg, spare: cand_reg};
        end else begin
            waddr = sh_reg[IW-1:0];
            wdata = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpc_reg       <= 19'd1;
            spt_reg       <= 11'd1;
            heads_reg     <= 9'd1;
            last_cyl_reg  <= 16'd0;
            spare_top_reg <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLOCKS_PER_CYL: bpc_reg       <= cfg_data;
                CFG_SECTORS:        spt_reg       <= cfg_data[10:0];
                CFG_HEADS:          heads_reg     <= cfg_data[8:0];
                CFG_LAST_CYL:       last_cyl_reg  <= cfg_data[15:0];
                CFG_SPARE_TOP:      spare_top_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_tuser;
            cyl_reg  <= s_tdata[15:0];
            head_reg <= s_tdata[23:16];
            sect_reg <= s_tdata[33:24];
            pos_reg  <= s_tdata[41:34];
            look_reg <= s_tdata[73:42];
        end
        if (cmd.mul) begin
            p1_reg <= prod_a[31:0];
            p2_reg <= prod_b;
        end
        if (cmd.sum) begin
            blk_reg  <= blk_next;
            cand_reg <= spare_top_reg;
        end else if (cmd.cand_dec) begin
            cand_reg <= cand_reg - 16'd1;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.sh_load_count) begin
            sh_reg <= count_reg;
        end else if (cmd.sh_load_pos) begin
            sh_reg <= pos_ext[CW-1:0];
        end else if (cmd.sh_dec) begin
            sh_reg <= sh_dn;
        end else if (cmd.sh_inc) begin
            sh_reg <= sh_up;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.cnt_dec) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_comb begin
        res_status_next = ST_OK;
        res_block_next  = '0;
        res_spare_next  = '0;
        res_pos_next    = '0;
        res_hit_next    = 1'b0;
        case (cmd.res_sel)
            RES_ERR: begin
                res_status_next = cmd.res_status;
            end
            RES_FULL: begin
                res_status_next = ST_FULL;
                res_block_next  = blk_reg;
            end
            RES_DUP: begin
                res_status_next = ST_DUP;
                res_block_next  = blk_reg;
                res_spare_next  = rdata_reg.spare;
                res_pos_next    = idx_reg;
            end
            RES_NEW: begin
                res_block_next = blk_reg;
                res_spare_next = cand_reg;
                res_pos_next   = idx_reg;
            end
            RES_HIT: begin
                res_block_next = look_reg;
                res_spare_next = rdata_reg.spare;
                res_pos_next   = idx_reg;
                res_hit_next   = 1'b1;
            end
            RES_MISS: begin
                res_block_next = look_reg;
            end
            RES_ENTRY: begin
                res_block_next = rdata_reg.block;
                res_spare_next = rdata_reg.spare;
                res_pos_next   = pos_ext[CW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_en) begin
            res_status_reg <= res_status_next;
            res_block_reg  <= res_block_next;
            res_spare_reg  <= res_spare_next;
            res_pos_reg    <= res_pos_next;
            res_hit_reg    <= res_hit_next;
        end
        if (cmd.emit) begin
            m_data_reg <= {3'b0, cnt_ext[8:0], res_hit_reg, rpos_ext[7:0],
                           res_spare_reg, res_block_reg, res_status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        stat.req_type  = req_reg;
        stat.cyl_bad   = cyl_reg > last_cyl_reg;
        stat.head_bad  = {1'b0, head_reg} >= heads_reg;
        stat.sect_bad  = {1'b0, sect_reg} >= spt_reg;
        stat.pos_bad   = pos_ext >= cnt_ext;
        stat.cand_low  = cand_reg <= 16'(SPARE_FLOOR);
        stat.idx_end   = idx_reg == count_reg;
        stat.spare_eq  = rdata_reg.spare == cand_reg;
        stat.blk_eq    = rdata_reg.block == blk_reg;
        stat.blk_gt    = rdata_reg.block > blk_reg;
        stat.look_eq   = rdata_reg.block == look_reg;
        stat.full      = count_reg == CW'(MAX_ENTRIES);
        stat.sh_at_idx = sh_reg == idx_reg;
        stat.del_end   = sh_up == count_reg;
        stat.out_busy  = m_valid_reg && !m_tready;
    end

    `BBRT_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_ENTRIES))
    `BBRT_ASSERT_NXT(a_count_inc, aclk, aresetn, cmd.cnt_inc, count_reg == $past(count_reg) + 1'b1)
    `BBRT_ASSERT_IMP(a_hit_ok, aclk, aresetn, m_valid_reg && m_data_reg[59], m_data_reg[2:0] == ST_OK)
    `BBRT_ASSERT_IMP(a_no_rw_busy, aclk, aresetn, cmd.emit, !stat.out_busy)

endmodule
`default_nettype wire

// ===== rtl/bbrt_controller.sv =====
// Controller state machine of the bad block remap table.
`default_nettype none
module bbrt_controller (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire bbrt_pkg::dp_stat_t  stat,
    output bbrt_pkg::dp_cmd_t        cmd
);
    import bbrt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.idx_clr = 1'b1;
                case (stat.req_type)
                    REQ_ADD: begin
                        cmd.mul     = 1'b1;
                        cmd.res_sel = RES_ERR;
                        if (stat.cyl_bad) begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_CYL;
                            state_next     = S_FINISH;
                        end else if (stat.head_bad) begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_HEAD;
                            state_next     = S_FINISH;
                        end else if (stat.sect_bad) begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_SECT;
                            state_next     = S_FINISH;
                        end else begin
                            state_next = S_SUM;
                        end
                    end
                    REQ_LOOKUP: begin
                        state_next = S_LK_RD;
                    end
                    default: begin
                        if (stat.pos_bad) begin
                            cmd.res_en     = 1'b1;
                            cmd.res_sel    = RES_ERR;
                            cmd.res_status = ST_POS;
                            state_next     = S_FINISH;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_POS;
                            state_next = S_POS_CHK;
                        end
                    end
                endcase
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_SP_TEST;
            end
            S_SP_TEST: begin
                cmd.idx_clr = 1'b1;
                if (stat.cand_low) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_FULL;
                    state_next  = S_FINISH;
                end else begin
                    state_next = S_SP_RD;
                end
            end
            S_SP_RD: begin
                if (stat.idx_end) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DUP_RD;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX;
                    state_next = S_SP_CHK;
                end
            end
            S_SP_CHK: begin
                if (stat.spare_eq) begin
                    cmd.cand_dec = 1'b1;
                    state_next   = S_SP_TEST;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SP_RD;
                end
            end
            S_DUP_RD: begin
                if (stat.idx_end) begin
                    state_next = S_INS_START;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX;
                    state_next = S_DUP_CHK;
                end
            end
            S_DUP_CHK: begin
                if (stat.blk_eq) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_DUP;
                    state_next  = S_FINISH;
                end else if (stat.blk_gt) begin
                    state_next = S_INS_START;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_DUP_RD;
                end
            end
            S_INS_START: begin
                if (stat.full) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_FULL;
                    state_next  = S_FINISH;
                end else begin
                    cmd.sh_load_count = 1'b1;
                    state_next        = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (stat.sh_at_idx) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_NEW;
                    cmd.cnt_inc = 1'b1;
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_NEW;
                    state_next  = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_SH_DN;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.sh_dec = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_LK_RD: begin
                if (stat.idx_end) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_MISS;
                    state_next  = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX;
                    state_next = S_LK_CHK;
                end
            end
            S_LK_CHK: begin
                if (stat.look_eq) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_HIT;
                    state_next  = S_FINISH;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_LK_RD;
                end
            end
            S_POS_CHK: begin
                cmd.res_en  = 1'b1;
                cmd.res_sel = RES_ENTRY;
                if (stat.req_type == REQ_DELETE) begin
                    cmd.sh_load_pos = 1'b1;
                    state_next      = S_DEL_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_DEL_RD: begin
                if (stat.del_end) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_SH_UP;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.sh_inc = 1'b1;
                state_next = S_DEL_RD;
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/bad_block_remap_table.sv =====
// Bad block remap table: add, lookup and delete scan the entries; a read fetches one entry.
// One request is in work at a time; scans read the entry memory one entry at a time.
// A finished result waits in the output register while the next request is accepted.
// Synchronous active-low reset empties the table and restores register defaults.
`default_nettype none
module bad_block_remap_table #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cylinder[15:0], head[23:16], sector[33:24], position[41:34], lookup_block[73:42]
    input  wire logic [79:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], entry_block[34:3], entry_spare[50:35], entry_position[58:51],
    // hit[59], entry_count[68:60]
    output logic [71:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [18:0] cfg_data
);
    import bbrt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bbrt_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbrt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== verif/bad_block_remap_table_tb.sv =====
// Self-checking testbench for the bad block remap table: directed table plus random requests.
`default_nettype none
module bad_block_remap_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bbrt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] blk;
        logic [15:0] spare;
        logic [7:0]  pos;
        logic        hit;
        logic [8:0]  count;
    } remap_result_t;

    typedef struct {
        bit            is_cfg;
        logic [1:0]    req;
        logic [15:0]   cyl;
        logic [7:0]    hd;
        logic [9:0]    sec;
        logic [7:0]    pos;
        logic [31:0]   look;
        bit            typed;
        remap_result_t want;
        logic [18:0]   geo [5];
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [18:0] cfg_data;

    bad_block_remap_table dut (.*);

    logic [31:0]   tbl_block [256];
    logic [15:0]   tbl_spare [256];
    int unsigned   tbl_count;
    logic [18:0]   geo_bpc;
    logic [10:0]   geo_spt;
    logic [8:0]    geo_heads;
    logic [15:0]   geo_last_cyl;
    logic [15:0]   geo_spare_top;
    remap_result_t pending_results [$];
    int unsigned   fail_count;
    bit            calm;
    bit            hold_req;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("bad_block_remap_table verification failed");
        $finish;
    end

    function automatic remap_result_t apply_request(logic [1:0] req, logic [15:0] cyl,
                                                    logic [7:0] hd, logic [9:0] sec,
                                                    logic [7:0] pos, logic [31:0] look);
        remap_result_t r;
        logic [31:0] b;
        logic [15:0] sp;
        int s;
        int i;
        bit used;
        r = '0;
        case (req)
            REQ_ADD: begin
                if (cyl > geo_last_cyl) begin
                    r.status = ST_CYL;
                end else if (hd >= geo_heads) begin
                    r.status = ST_HEAD;
                end else if (sec >= geo_spt) begin
                    r.status = ST_SECT;
                end else begin
                    b = 32'(cyl) * 32'(geo_bpc) + 32'(hd) * 32'(geo_spt) + 32'(sec);
                    sp = '0;
                    for (s = geo_spare_top; s > SPARE_FLOOR && sp == 0; s--) begin
                        used = 1'b0;
                        for (i = 0; i < tbl_count; i++)
                            if (tbl_spare[i] == s) used = 1'b1;
                        if (!used) sp = 16'(s);
                    end
                    r.blk = b;
                    i = 0;
                    while (i < tbl_count && tbl_block[i] < b) i++;
                    if (sp == 0) begin
                        r.status = ST_FULL;
                    end else if (i < tbl_count && tbl_block[i] == b) begin
                        r.status = ST_DUP;
                        r.spare = tbl_spare[i];
                        r.pos = 8'(i);
                    end else if (tbl_count >= 256) begin
                        r.status = ST_FULL;
                    end else begin
                        for (s = tbl_count; s > i; s--) begin
                            tbl_block[s] = tbl_block[s-1];
                            tbl_spare[s] = tbl_spare[s-1];
                        end
                        tbl_block[i] = b;
                        tbl_spare[i] = sp;
                        tbl_count++;
                        r.status = ST_OK;
                        r.spare = sp;
                        r.pos = 8'(i);
                    end
                end
            end
            REQ_LOOKUP: begin
                r.status = ST_OK;
                r.blk = look;
                for (i = 0; i < tbl_count && !r.hit; i++) begin
                    if (tbl_block[i] == look) begin
                        r.hit = 1'b1;
                        r.spare = tbl_spare[i];
                        r.pos = 8'(i);
                    end
                end
            end
            default: begin
                if (pos >= tbl_count) begin
                    r.status = ST_POS;
                end else begin
                    r.status = ST_OK;
                    r.blk = tbl_block[pos];
                    r.spare = tbl_spare[pos];
                    r.pos = pos;
                    if (req == REQ_DELETE) begin
                        for (i = pos; i + 1 < tbl_count; i++) begin
                            tbl_block[i] = tbl_block[i+1];
                            tbl_spare[i] = tbl_spare[i+1];
                        end
                        tbl_count--;
                    end
                end
            end
        endcase
        r.count = 9'(tbl_count);
        return r;
    endfunction

    function automatic plan_row_t req_row(logic [1:0] req, logic [15:0] cyl, logic [7:0] hd,
                                          logic [9:0] sec, logic [7:0] pos, logic [31:0] look);
        plan_row_t p;
        p = '{default: '0, geo: '{default: '0}};
        p.req = req;
        p.cyl = cyl;
        p.hd = hd;
        p.sec = sec;
        p.pos = pos;
        p.look = look;
        return p;
    endfunction

    function automatic plan_row_t want_row(plan_row_t p, logic [2:0] st, logic [31:0] blk,
                                           logic [15:0] sp, logic [7:0] ps, logic hit,
                                           logic [8:0] cnt);
        p.typed = 1'b1;
        p.want = '{status: st, blk: blk, spare: sp, pos: ps, hit: hit, count: cnt};
        return p;
    endfunction

    function automatic plan_row_t cfg_row(logic [18:0] bpc, logic [18:0] spt, logic [18:0] hc,
                                          logic [18:0] lc, logic [18:0] top);
        plan_row_t p;
        p = '{default: '0, geo: '{default: '0}};
        p.is_cfg = 1'b1;
        p.geo = '{bpc, spt, hc, lc, top};
        return p;
    endfunction

    task automatic send_request(plan_row_t p);
        remap_result_t got;
        s_tvalid <= 1'b1;
        s_tuser <= p.req;
        s_tdata <= {6'd0, p.look, p.pos, p.sec, p.hd, p.cyl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = apply_request(p.req, p.cyl, p.hd, p.sec, p.pos, p.look);
        pending_results.push_back(p.typed ? p.want : got);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_geometry(logic [18:0] v [5]);
        logic [2:0] names [5];
        names = '{CFG_BLOCKS_PER_CYL, CFG_SECTORS, CFG_HEADS, CFG_LAST_CYL, CFG_SPARE_TOP};
        for (int k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= names[k];
            cfg_data <= v[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (names[k])
                CFG_BLOCKS_PER_CYL: geo_bpc = v[k];
                CFG_SECTORS:        geo_spt = v[k][10:0];
                CFG_HEADS:          geo_heads = v[k][8:0];
                CFG_LAST_CYL:       geo_last_cyl = v[k][15:0];
                default:            geo_spare_top = v[k][15:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic plan_row_t random_request();
        int r;
        logic [1:0] req;
        plan_row_t p;
        p = req_row(2'($urandom), 16'($urandom), 8'($urandom), 10'($urandom),
                    8'($urandom), $urandom);
        r = $urandom_range(0, 99);
        if (tbl_count > 20 && r < 40) req = REQ_DELETE;
        else if (r < 50) req = REQ_ADD;
        else if (r < 65) req = REQ_LOOKUP;
        else if (r < 80) req = REQ_READ;
        else req = REQ_DELETE;
        p.req = req;
        if ($urandom_range(0, 99) < 85) begin
            p.cyl = 16'($urandom_range(0, geo_last_cyl));
            p.hd = (geo_heads == 0) ? 8'd0 : 8'($urandom_range(0, geo_heads - 1));
            p.sec = (geo_spt == 0) ? 10'd0 : 10'($urandom_range(0, geo_spt - 1));
            p.pos = 8'($urandom_range(0, tbl_count));
            if (tbl_count != 0 && $urandom_range(0, 1))
                p.look = tbl_block[$urandom_range(0, tbl_count - 1)];
        end
        return p;
    endfunction

    always @(posedge aclk) begin
        remap_result_t act;
        remap_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            act = '{status: m_tdata[2:0], blk: m_tdata[34:3], spare: m_tdata[50:35],
                    pos: m_tdata[58:51], hit: m_tdata[59], count: m_tdata[68:60]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, act);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (act.status != exp_r.status)
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             act.status);
                if (act.blk != exp_r.blk)
                    $display("%0t: entry_block expected %h actual %h", $time, exp_r.blk,
                             act.blk);
                if (act.spare != exp_r.spare)
                    $display("%0t: entry_spare expected %0d actual %0d", $time, exp_r.spare,
                             act.spare);
                if (act.pos != exp_r.pos)
                    $display("%0t: entry_position expected %0d actual %0d", $time, exp_r.pos,
                             act.pos);
                if (act.hit != exp_r.hit)
                    $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, act.hit);
                if (act.count != exp_r.count)
                    $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.count,
                             act.count);
                if (act != exp_r) fail_count++;
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (4000) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    initial begin
        plan_row_t plan [$];
        plan_row_t p;
        logic [18:0] g [5];
        bit gappy;
        int n_items;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        tbl_count = 0;
        geo_bpc = 1;
        geo_spt = 1;
        geo_heads = 1;
        geo_last_cyl = 0;
        geo_spare_top = 0;
        fail_count = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        plan.push_back(want_row(req_row(REQ_READ, 0, 0, 0, 0, 0), ST_POS, 0, 0, 0, 0, 0));
        plan.push_back(want_row(req_row(REQ_DELETE, 0, 0, 0, 255, 0), ST_POS, 0, 0, 0, 0, 0));
        plan.push_back(want_row(req_row(REQ_LOOKUP, 0, 0, 0, 0, '1), ST_OK, '1, 0, 0, 0, 0));
        plan.push_back(want_row(req_row(REQ_ADD, 1, 0, 0, 0, 0), ST_CYL, 0, 0, 0, 0, 0));
        plan.push_back(want_row(req_row(REQ_ADD, 0, 1, 0, 0, 0), ST_HEAD, 0, 0, 0, 0, 0));
        plan.push_back(want_row(req_row(REQ_ADD, 0, 0, 1, 0, 0), ST_SECT, 0, 0, 0, 0, 0));
        plan.push_back(want_row(req_row(REQ_ADD, 0, 0, 0, 0, 0), ST_FULL, 0, 0, 0, 0, 0));
        plan.push_back(cfg_row(1, 1, 1, 0, 4));
        plan.push_back(want_row(req_row(REQ_ADD, 0, 0, 0, 0, 0), ST_OK, 0, 4, 0, 0, 1));
        plan.push_back(want_row(req_row(REQ_ADD, 0, 0, 0, 0, 0), ST_FULL, 0, 0, 0, 0, 1));
        plan.push_back(want_row(req_row(REQ_LOOKUP, 0, 0, 0, 0, 0), ST_OK, 0, 4, 0, 1, 1));
        plan.push_back(want_row(req_row(REQ_READ, 0, 0, 0, 0, 0), ST_OK, 0, 4, 0, 0, 1));
        plan.push_back(want_row(req_row(REQ_DELETE, 0, 0, 0, 0, 0), ST_OK, 0, 4, 0, 0, 0));
        plan.push_back(cfg_row(262144, 1024, 256, 65535, 65535));
        plan.push_back(req_row(REQ_ADD, 65535, 255, 1023, 0, 0));
        plan.push_back(req_row(REQ_ADD, 0, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_ADD, 65535, 255, 1023, 0, 0));
        plan.push_back(req_row(REQ_ADD, 1, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_LOOKUP, 0, 0, 0, 0, 262144));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 2, 0));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 3, 0));
        plan.push_back(req_row(REQ_DELETE, 0, 0, 0, 1, 0));
        plan.push_back(cfg_row(5, 0, 256, 10, 20));
        plan.push_back(req_row(REQ_ADD, 1, 3, 0, 0, 0));
        plan.push_back(req_row(REQ_ADD, 11, 0, 0, 0, 0));
        plan.push_back(cfg_row(5, 2, 0, 10, 20));
        plan.push_back(req_row(REQ_ADD, 0, 0, 0, 0, 0));

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain_results();
                write_geometry(plan[k].geo);
            end else begin
                send_request(plan[k]);
            end
        end

        for (int ph = 0; ph < 13; ph++) begin
            drain_results();
            g[0] = (ph == 3) ? 19'd262144 : 19'($urandom_range(1, 40));
            g[1] = (ph == 5) ? 19'd0 : (ph == 3) ? 19'd1024 : 19'($urandom_range(1, 8));
            g[2] = (ph == 7) ? 19'd0 : (ph == 3) ? 19'd256 : 19'($urandom_range(1, 4));
            g[3] = (ph == 3) ? 19'd65535 : 19'($urandom_range(0, 7));
            g[4] = (ph == 3) ? 19'd65535 : (ph == 9) ? 19'($urandom_range(0, 3))
                                                     : 19'($urandom_range(4, 30));
            write_geometry(g);
            calm = (ph == 12);
            gappy = !calm && $urandom_range(0, 3) != 0;
            n_items = 88;
            for (int k = 0; k < n_items; k++) begin
                if (ph == 2 && k == 10) hold_req = 1'b1;
                if (gappy && $urandom_range(0, 2) == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge aclk);
                end
                if (ph == 2 && k < 20) p = random_request();
                else p = random_request();
                send_request(p);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("bad_block_remap_table verification clean");
        end else begin
            $display("bad_block_remap_table verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/bbrt_pkg.sv
rtl/bbrt_datapath.sv
rtl/bbrt_controller.sv
rtl/bad_block_remap_table.sv
verif/bad_block_remap_table_tb.sv
